/* hdl/wwmf_pkg.sv */
// ----------------------------------------------------------------------------
// wwmf_pkg
// Shared types, constants and helper functions of the whole-word mask filter.
// ----------------------------------------------------------------------------
`default_nettype none

package wwmf_pkg;

  // Default depth of the word buffer, in characters.
  localparam int MAX_WORD_DEF = 8;
  // The target register holds at most this many characters.
  localparam int TARGET_CHARS = 8;
  // Default depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] MASK_CHAR = 8'h2A;

  // Configuration port geometry: two registers at byte addresses 0 and 8.
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 64;
  localparam int REG_SEL_BIT = 3;
  localparam logic REG_TARGET_WORD   = 1'b0;
  localparam logic REG_TARGET_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    CMD_WORD,
    CMD_SEP,
    CMD_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] ch;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  typedef enum logic [1:0] {
    BK_DISPATCH,
    BK_FLUSH,
    BK_TAIL
  } back_state_t;

  // Space , ; : . " ! ? ' and newline end a word.
  function automatic logic is_separator(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h2C) || (c == 8'h3B) || (c == 8'h3A) ||
           (c == 8'h2E) || (c == 8'h22) || (c == 8'h21) || (c == 8'h3F) ||
           (c == 8'h27) || (c == 8'h0A);
  endfunction

  function automatic logic [7:0] upper_ascii(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/wwmf_in_if.sv */
// ----------------------------------------------------------------------------
// wwmf_in_if
// Valid/ready channel carrying one text character or an end-of-text mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface wwmf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_text;

  modport source (output valid, output char_in, output end_of_text, input ready);
  modport sink   (input valid, input char_in, input end_of_text, output ready);
endinterface

`default_nettype wire

/* hdl/wwmf_out_if.sv */
// ----------------------------------------------------------------------------
// wwmf_out_if
// Valid/ready channel carrying one output character and its end-of-run flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface wwmf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last_of_run;

  modport source (output valid, output char_out, output last_of_run, input ready);
  modport sink   (input valid, input char_out, input last_of_run, output ready);
endinterface

`default_nettype wire

/* hdl/wwmf_front.sv */
// ----------------------------------------------------------------------------
// wwmf_front
// Accepts input characters and classifies each as word character, separator or end.
// ----------------------------------------------------------------------------
`default_nettype none

module wwmf_front import wwmf_pkg::*; (
  wwmf_in_if.sink       text_in,
  input  queue_status_t q_status,
  output logic          push,
  output cmd_t          push_cmd
);

  assign text_in.ready = !q_status.full;
  assign push          = text_in.valid && !q_status.full;

  always_comb begin
    push_cmd.ch = text_in.char_in;
    if (text_in.end_of_text) begin
      push_cmd.kind = CMD_END;
    end else if (is_separator(text_in.char_in)) begin
      push_cmd.kind = CMD_SEP;
    end else begin
      push_cmd.kind = CMD_WORD;
    end
  end

endmodule

`default_nettype wire

/* hdl/wwmf_queue.sv */
// ----------------------------------------------------------------------------
// wwmf_queue
// Short command queue that decouples the classifier from the word engine.
// ----------------------------------------------------------------------------
`default_nettype none

module wwmf_queue import wwmf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cmd_t          push_cmd,
  input  logic          pop,
  output cmd_t          head,
  output queue_status_t status
);

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  cmd_t              slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  assign head         = slots[rd_ptr];
  assign status.empty = (fill == '0);
  assign status.full  = (fill == FILL_W'(DEPTH));

endmodule

`default_nettype wire

/* hdl/wwmf_back.sv */
// ----------------------------------------------------------------------------
// wwmf_back
// Word engine: buffers word characters, compares against the target and
// releases each word, masked or unchanged, through a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module wwmf_back import wwmf_pkg::*; #(
  parameter int MAX_WORD = MAX_WORD_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [63:0]   target_word,
  input  logic [3:0]    target_length,
  input  cmd_t          head,
  input  queue_status_t q_status,
  output logic          pop,
  wwmf_out_if.source    text_out
);

  localparam int CNT_W     = $clog2(MAX_WORD + 1);
  localparam int IDX_W     = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int CMP_CHARS = (MAX_WORD < TARGET_CHARS) ? MAX_WORD : TARGET_CHARS;

  back_state_t state;
  back_state_t state_next;

  logic [7:0]       word_buffer [MAX_WORD];
  logic [CNT_W-1:0] word_count;
  logic             overlong_word;
  logic [IDX_W-1:0] rd_idx;
  logic             mask_word;
  logic             tail_pending;
  logic [7:0]       tail_char;

  logic             out_valid;
  logic [7:0]       out_char;
  logic             out_last;

  logic                 slot_free;
  logic                 last_idx;
  logic                 len_ok;
  logic                 word_match;
  logic [CMP_CHARS-1:0] char_ok;

  logic       store;
  logic       emit;
  logic [7:0] emit_char;
  logic       emit_last;
  logic       load_flush;
  logic       flush_mask;
  logic       flush_tail;
  logic       ovl_set;
  logic       ovl_clr;
  logic       idx_step;

  assign slot_free = !out_valid || text_out.ready;
  assign last_idx  = (int'(rd_idx) == int'(word_count) - 1);

  // Positions at or beyond the target length are don't-care.
  for (genvar i = 0; i < CMP_CHARS; i++) begin : g_cmp
    assign char_ok[i] = (i >= int'(target_length)) ||
                        (upper_ascii(word_buffer[i]) == upper_ascii(target_word[8*i +: 8]));
  end

  assign len_ok     = (target_length != '0) && (int'(target_length) <= CMP_CHARS) &&
                      (int'(word_count) == int'(target_length));
  assign word_match = len_ok && (&char_ok);

  always_comb begin
    state_next = state;
    case (state)
      BK_DISPATCH: begin
        if (!q_status.empty && slot_free) begin
          case (head.kind)
            CMD_WORD: begin
              if (!overlong_word && int'(word_count) == MAX_WORD) begin
                state_next = BK_FLUSH;
              end
            end
            CMD_SEP, CMD_END: begin
              if (word_count != '0) begin
                state_next = BK_FLUSH;
              end
            end
            default: ;
          endcase
        end
      end
      BK_FLUSH: begin
        if (slot_free && last_idx) begin
          state_next = tail_pending ? BK_TAIL : BK_DISPATCH;
        end
      end
      BK_TAIL: begin
        if (slot_free) begin
          state_next = BK_DISPATCH;
        end
      end
      default: state_next = BK_DISPATCH;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    store      = 1'b0;
    emit       = 1'b0;
    emit_char  = head.ch;
    emit_last  = 1'b1;
    load_flush = 1'b0;
    flush_mask = 1'b0;
    flush_tail = 1'b0;
    ovl_set    = 1'b0;
    ovl_clr    = 1'b0;
    idx_step   = 1'b0;
    case (state)
      BK_DISPATCH: begin
        if (!q_status.empty && slot_free) begin
          pop = 1'b1;
          case (head.kind)
            CMD_WORD: begin
              if (overlong_word) begin
                emit = 1'b1;
              end else if (int'(word_count) < MAX_WORD) begin
                store = 1'b1;
              end else begin
                load_flush = 1'b1;
                flush_tail = 1'b1;
                ovl_set    = 1'b1;
              end
            end
            CMD_SEP: begin
              ovl_clr = 1'b1;
              if (word_count == '0) begin
                emit = 1'b1;
              end else begin
                load_flush = 1'b1;
                flush_tail = 1'b1;
                flush_mask = !overlong_word && word_match;
              end
            end
            CMD_END: begin
              ovl_clr = 1'b1;
              if (word_count != '0) begin
                load_flush = 1'b1;
                flush_mask = !overlong_word && word_match;
              end
            end
            default: ;
          endcase
        end
      end
      BK_FLUSH: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = mask_word ? MASK_CHAR : word_buffer[rd_idx];
          emit_last = last_idx && !tail_pending;
          idx_step  = 1'b1;
        end
      end
      BK_TAIL: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = tail_char;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_DISPATCH;
      word_count    <= '0;
      overlong_word <= 1'b0;
      rd_idx        <= '0;
      mask_word     <= 1'b0;
      tail_pending  <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (store) begin
        word_count <= word_count + CNT_W'(1);
      end
      if (idx_step) begin
        if (last_idx) begin
          rd_idx     <= '0;
          word_count <= '0;
        end else begin
          rd_idx <= rd_idx + IDX_W'(1);
        end
      end
      if (ovl_set) begin
        overlong_word <= 1'b1;
      end else if (ovl_clr) begin
        overlong_word <= 1'b0;
      end
      if (load_flush) begin
        mask_word    <= flush_mask;
        tail_pending <= flush_tail;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (text_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      word_buffer[word_count[IDX_W-1:0]] <= head.ch;
    end
    if (load_flush) begin
      tail_char <= head.ch;
    end
    if (emit) begin
      out_char <= emit_char;
      out_last <= emit_last;
    end
  end

  assign text_out.valid       = out_valid;
  assign text_out.char_out    = out_char;
  assign text_out.last_of_run = out_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(word_count) <= MAX_WORD)
    else $error("word buffer fill count beyond its depth");

  a_overlong_empty: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DISPATCH && overlong_word) |-> (word_count == '0))
    else $error("characters buffered while an overlong word passes through");

  a_mask_length: assert property (@(posedge clk) disable iff (rst)
    (state == BK_FLUSH && mask_word) |-> (int'(word_count) == int'(target_length)))
    else $error("masked release of a word whose length differs from the target");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("command taken from an empty queue");

endmodule

`default_nettype wire

/* hdl/whole_word_mask_filter_unit.sv */
// ----------------------------------------------------------------------------
// whole_word_mask_filter_unit
// Case-insensitive whole-word censor: replaces every word equal to the target
// word by asterisks and passes all other characters through.
// ----------------------------------------------------------------------------
// Path: a character that passes straight through is held in the command queue
//   and then in the output register before it appears on the output.
// Flow: while the back end releases a buffered word and its ending separator it
//   takes no new command; the queue keeps accepting characters until it is full.
// Reset: rst is synchronous; it empties the queue, the word buffer count and
//   the overlong flag and clears both configuration registers. No clearing pass.
`default_nettype none

module whole_word_mask_filter_unit import wwmf_pkg::*; #(
  parameter int MAX_WORD = MAX_WORD_DEF,
  parameter int Q_DEPTH  = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  wwmf_in_if.sink            text_in,
  wwmf_out_if.source         text_out
);

  // Configuration registers. The target word holds up to eight characters with
  // the first character in the low byte; a length of zero turns matching off.
  logic [63:0] target_word;
  logic [3:0]  target_length;
  logic        cfg_wr;

  // The port never inserts wait states, so a write completes in its access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_word   <= '0;
      target_length <= '0;
    end else if (cfg_wr) begin
      case (paddr[REG_SEL_BIT])
        REG_TARGET_WORD:   target_word   <= pwdata;
        REG_TARGET_LENGTH: target_length <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[REG_SEL_BIT])
      REG_TARGET_WORD:   prdata = target_word;
      REG_TARGET_LENGTH: prdata = {{(PDATA_W - 4){1'b0}}, target_length};
      default:           prdata = '0;
    endcase
  end

  // Front end: tags each accepted character as a word character, a separator or an
  // end-of-text mark and pushes it into the queue whenever there is room.
  queue_status_t q_status;
  logic          push;
  cmd_t          push_cmd;
  logic          pop;
  cmd_t          head;

  wwmf_front u_front (
    .text_in  (text_in),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // The queue lets the front keep taking characters while the back end is busy
  // releasing a buffered word or waiting on a stalled output.
  wwmf_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // Back end: holds the current word, decides on a separator or end of text
  // whether it matches the target, and drives the output register.
  wwmf_back #(
    .MAX_WORD (MAX_WORD)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .target_word   (target_word),
    .target_length (target_length),
    .head          (head),
    .q_status      (q_status),
    .pop           (pop),
    .text_out      (text_out)
  );

endmodule

`default_nettype wire
